/* rtl/rc6_block_cipher_core_macros.svh */
// ----------------------------------------------------------------------------
// rc6_block_cipher_core_macros
// Assertion macros shared by the RC6 checker.
// ----------------------------------------------------------------------------
`ifndef RC6_BLOCK_CIPHER_CORE_MACROS_SVH
`define RC6_BLOCK_CIPHER_CORE_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define RC6_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc6 check failed");

// Consequent checked in the same cycle as the antecedent.
`define RC6_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc6 check failed");

`endif

/* rtl/rc6_pkg.sv */
// ----------------------------------------------------------------------------
// rc6_pkg
// Types, constants and word helpers shared by the RC6 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc6_pkg;

    localparam int DEF_ROUNDS = 20;
    localparam int KEY_WORDS  = 4;
    localparam logic [31:0] MAGIC_P = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

    typedef enum logic [1:0] {
        REQ_KEY = 2'd0,
        REQ_ENC = 2'd1,
        REQ_DEC = 2'd2,
        REQ_NOP = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_A,
        ST_MIX_B,
        ST_PRE0,
        ST_PRE1,
        ST_PRE2,
        ST_RND0,
        ST_RND1,
        ST_RND2,
        ST_POST0,
        ST_POST1,
        ST_POST2,
        ST_DONE
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

endpackage

`default_nettype wire

/* rtl/rc6_ram.sv */
// ----------------------------------------------------------------------------
// rc6_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc6_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/rc6_qmix.sv */
// ----------------------------------------------------------------------------
// rc6_qmix
// Shared quadratic mixer: rotl(x * (2x + 1), 5), modulo 2^32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc6_qmix import rc6_pkg::*; (
    input  wire logic [31:0] x,
    output logic      [31:0] y
);

    logic [31:0] odd;
    logic [31:0] prod;

    assign odd  = {x[30:0], 1'b1};
    assign prod = x * odd;
    assign y    = rotl32(prod, 5'd5);

endmodule

`default_nettype wire

/* rtl/rc6_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// rc6_block_cipher_core
// RC6-32/R/16 engine: key expansion into a round-key RAM and iterative
// encrypt/decrypt with one shared multiplier.
// ----------------------------------------------------------------------------
// channel  handshake            payload
// in       in_valid/in_ready    req_type, key_low, key_high, word_a..word_d
// out      out_valid/out_ready  out_a, out_b, out_c, out_d
//
// Block word: PRE0..2 whitening, RND0..2 per round, POST0..2 whitening, DONE;
// each round reads two keys through the single RAM read port and runs the
// multiplier twice. Set-key word: fill with P + s*Q, then MIX_RD/MIX_A/MIX_B steps.
// Reset clears control only; round keys are undefined until the first set key.
// in_ready is high only when idle; a finished word waits in the output
// register, and a following block holds in its last step until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc6_block_cipher_core import rc6_pkg::*; #(
    parameter int ROUNDS = DEF_ROUNDS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [63:0] key_low,
    input  wire logic [63:0] key_high,
    input  wire logic [31:0] word_a,
    input  wire logic [31:0] word_b,
    input  wire logic [31:0] word_c,
    input  wire logic [31:0] word_d,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [31:0] out_a,
    output logic      [31:0] out_b,
    output logic      [31:0] out_c,
    output logic      [31:0] out_d
);

    localparam int SCHED_LEN = 2 * ROUNDS + 4;
    localparam int AW        = $clog2(SCHED_LEN);
    localparam int MIX_STEPS = 3 * ((SCHED_LEN > KEY_WORDS) ? SCHED_LEN : KEY_WORDS);
    localparam int SW        = $clog2(MIX_STEPS);
    localparam int KW        = $clog2(ROUNDS + 1);
    localparam logic [AW-1:0] ADDR_LAST  = AW'(SCHED_LEN - 1);
    localparam logic [AW-1:0] ADDR_LAST2 = AW'(SCHED_LEN - 2);
    localparam logic [SW-1:0] STEP_LAST  = SW'(MIX_STEPS - 1);
    localparam logic [KW-1:0] K_LAST     = KW'(ROUNDS);

    state_t state_reg, state_next;
    logic dec_reg, dec_next;
    logic [31:0] wa_reg, wa_next, wb_reg, wb_next, wc_reg, wc_next, wd_reg, wd_next;
    logic [31:0] t_reg, t_next, u_reg, u_next, key0_reg, key0_next;
    logic [31:0] kw_reg [KEY_WORDS];
    logic [31:0] kw_next [KEY_WORDS];
    logic [AW-1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [SW-1:0] step_reg, step_next;
    logic [KW-1:0] k_reg, k_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] oa_reg, oa_next, ob_reg, ob_next, oc_reg, oc_next, od_reg, od_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;
    logic [31:0] qm_in, qm_out;

    logic [31:0] mix_a, mix_ab, mix_b;
    logic [AW-1:0] key_even, key_odd;

    rc6_ram #(
        .WIDTH (32),
        .DEPTH (SCHED_LEN)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rc6_qmix u_qmix (
        .x (qm_in),
        .y (qm_out)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_a     = oa_reg;
    assign out_b     = ob_reg;
    assign out_c     = oc_reg;
    assign out_d     = od_reg;

    assign key_even = AW'({k_reg, 1'b0});
    assign key_odd  = AW'({k_reg, 1'b1});
    assign mix_a    = rotl32(ram_rdata + wa_reg + wb_reg, 5'd3);
    assign mix_ab   = wa_reg + wb_reg;
    assign mix_b    = rotl32(kw_reg[j_reg] + mix_ab, mix_ab[4:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg  <= dec_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        wc_reg   <= wc_next;
        wd_reg   <= wd_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        key0_reg <= key0_next;
        kw_reg   <= kw_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        step_reg <= step_next;
        k_reg    <= k_next;
        oa_reg   <= oa_next;
        ob_reg   <= ob_next;
        oc_reg   <= oc_next;
        od_reg   <= od_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        dec_next       = dec_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        key0_next      = key0_reg;
        kw_next        = kw_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        oa_next        = oa_reg;
        ob_next        = ob_reg;
        oc_next        = oc_reg;
        od_next        = od_reg;
        ram_we         = 1'b0;
        ram_waddr      = i_reg;
        ram_wdata      = wc_reg;
        ram_raddr      = i_reg;
        qm_in          = dec_reg ? wa_reg : wb_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_KEY:
                        begin
                            kw_next[0] = key_low[31:0];
                            kw_next[1] = key_low[63:32];
                            kw_next[2] = key_high[31:0];
                            kw_next[3] = key_high[63:32];
                            wc_next    = MAGIC_P;
                            i_next     = '0;
                            state_next = ST_FILL;
                        end
                        REQ_ENC, REQ_DEC:
                        begin
                            dec_next   = (req_type == REQ_DEC);
                            wa_next    = word_a;
                            wb_next    = word_b;
                            wc_next    = word_c;
                            wd_next    = word_d;
                            state_next = ST_PRE0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // P + s*Q written one entry a cycle
                ram_we  = 1'b1;
                wc_next = wc_reg + MAGIC_Q;
                if (i_reg == ADDR_LAST)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    step_next  = '0;
                    wa_next    = '0;
                    wb_next    = '0;
                    state_next = ST_MIX_RD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_MIX_RD:
            begin
                state_next = ST_MIX_A;
            end
            ST_MIX_A:
            begin
                ram_we     = 1'b1;
                ram_wdata  = mix_a;
                wa_next    = mix_a;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                kw_next[j_reg] = mix_b;
                wb_next        = mix_b;
                j_next         = j_reg + 1'b1;
                i_next         = (i_reg == ADDR_LAST) ? '0 : i_reg + 1'b1;
                step_next      = step_reg + 1'b1;
                state_next     = (step_reg == STEP_LAST) ? ST_IDLE : ST_MIX_RD;
            end
            ST_PRE0:
            begin
                ram_raddr  = dec_reg ? ADDR_LAST2 : AW'(0);
                state_next = ST_PRE1;
            end
            ST_PRE1:
            begin
                ram_raddr = dec_reg ? ADDR_LAST : AW'(1);
                if (dec_reg)
                begin
                    wa_next = wa_reg - ram_rdata;
                end
                else
                begin
                    wb_next = wb_reg + ram_rdata;
                end
                state_next = ST_PRE2;
            end
            ST_PRE2:
            begin
                if (dec_reg)
                begin
                    wc_next = wc_reg - ram_rdata;
                    k_next  = K_LAST;
                end
                else
                begin
                    wd_next = wd_reg + ram_rdata;
                    k_next  = KW'(1);
                end
                state_next = ST_RND0;
            end
            ST_RND0:
            begin
                ram_raddr  = key_even;
                qm_in      = dec_reg ? wa_reg : wb_reg;
                t_next     = qm_out;
                state_next = ST_RND1;
            end
            ST_RND1:
            begin
                ram_raddr  = key_odd;
                qm_in      = dec_reg ? wc_reg : wd_reg;
                u_next     = qm_out;
                key0_next  = ram_rdata;
                state_next = ST_RND2;
            end
            ST_RND2:
            begin
                if (dec_reg)
                begin
                    wa_next = rotr32(wd_reg - key0_reg, u_reg[4:0]) ^ t_reg;
                    wb_next = wa_reg;
                    wc_next = rotr32(wb_reg - ram_rdata, t_reg[4:0]) ^ u_reg;
                    wd_next = wc_reg;
                    k_next  = k_reg - 1'b1;
                    state_next = (k_reg == KW'(1)) ? ST_POST0 : ST_RND0;
                end
                else
                begin
                    wa_next = wb_reg;
                    wb_next = rotl32(wc_reg ^ u_reg, t_reg[4:0]) + ram_rdata;
                    wc_next = wd_reg;
                    wd_next = rotl32(wa_reg ^ t_reg, u_reg[4:0]) + key0_reg;
                    k_next  = k_reg + 1'b1;
                    state_next = (k_reg == K_LAST) ? ST_POST0 : ST_RND0;
                end
            end
            ST_POST0:
            begin
                ram_raddr  = dec_reg ? AW'(1) : ADDR_LAST2;
                state_next = ST_POST1;
            end
            ST_POST1:
            begin
                ram_raddr = dec_reg ? AW'(0) : ADDR_LAST;
                if (dec_reg)
                begin
                    wd_next = wd_reg - ram_rdata;
                end
                else
                begin
                    wa_next = wa_reg + ram_rdata;
                end
                state_next = ST_POST2;
            end
            ST_POST2:
            begin
                if (dec_reg)
                begin
                    wb_next = wb_reg - ram_rdata;
                end
                else
                begin
                    wc_next = wc_reg + ram_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oa_next        = wa_reg;
                    ob_next        = wb_reg;
                    oc_next        = wc_reg;
                    od_next        = wd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/rc6_chk.sv */
// ----------------------------------------------------------------------------
// rc6_chk
// Port-level checks on the RC6 engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rc6_block_cipher_core_macros.svh"

module rc6_chk import rc6_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  req_type,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_a,
    input wire logic [31:0] out_d
);

    logic in_acc;
    logic work_acc;

    assign in_acc   = in_valid && in_ready;
    assign work_acc = in_acc && (req_type != REQ_NOP);

    `RC6_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_a) && $stable(out_d))
    `RC6_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, work_acc, !in_ready)
    `RC6_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))
    `RC6_ASSERT_NEXT(a_nop_stays_idle, clk, rst_n, in_acc && (req_type == REQ_NOP), in_ready)

endmodule

bind rc6_block_cipher_core rc6_chk u_rc6_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_a     (out_a),
    .out_d     (out_d)
);

`default_nettype wire
